### hw/rtl/dpwp_pkg.sv
`timescale 1ns / 1ps

package dpwp_pkg;

    // Port field widths
    localparam int PIX_W    = 10;
    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 8;

    // Default pixel coordinate width
    localparam int COORD_BITS_DEF = 10;

    // Pinhole intrinsics
    localparam int FOCAL     = 585;
    localparam int FOCAL_W   = 10;
    localparam int CENTRE_X  = 320;
    localparam int CENTRE_Y  = 240;
    localparam logic [DEPTH_W-1:0] DEPTH_INVALID = 16'hFFFF;

    // Pose register file
    localparam int NUM_REGS    = 8;
    localparam int NUM_ENTRIES = 16;

    // Output scaling: q = num * 8192 / (w * 125)
    localparam int SCALE_SHIFT = 13;
    localparam int DIV_K       = 125;
    localparam int DIV_K_W     = 7;

    // Quotient bits kept by the divider (saturation only needs 2^33)
    localparam int QUOT_BITS = 33;

    // Decoupling queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0] q16_t;

    // Width of one pose row dot product for a given coordinate width
    function automatic int sum_width(input int coord_bits);
        return coord_bits + 53;
    endfunction

endpackage

### hw/rtl/dpwp_front.sv
`timescale 1ns / 1ps

module dpwp_front #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [dpwp_pkg::PIX_W-1:0]        in_column,
    input  logic [dpwp_pkg::PIX_W-1:0]        in_row,
    input  logic [dpwp_pkg::DEPTH_W-1:0]      in_depth,
    input  dpwp_pkg::q16_t [dpwp_pkg::NUM_ENTRIES-1:0] pose,
    output logic                              out_valid,
    output logic [4*dpwp_pkg::sum_width(COORD_BITS):0] out_item
);

    localparam int SW  = dpwp_pkg::sum_width(COORD_BITS);
    localparam int PW  = SW - 2;
    localparam int DXW = COORD_BITS + 2;
    localparam int AW  = DXW + dpwp_pkg::DEPTH_W + 1;
    localparam int DKW = dpwp_pkg::DEPTH_W + dpwp_pkg::FOCAL_W;
    localparam int MDW = dpwp_pkg::COORD_W + DKW + 1;
    localparam int MFW = dpwp_pkg::COORD_W + dpwp_pkg::FOCAL_W + 1;

    // Stage 0: capture the pixel
    logic                        v0_reg;
    logic [COORD_BITS-1:0]       col0_reg;
    logic [COORD_BITS-1:0]       row0_reg;
    logic [dpwp_pkg::DEPTH_W-1:0] d0_reg;
    logic                        inv0_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        col0_reg <= COORD_BITS'(in_column);
        row0_reg <= COORD_BITS'(in_row);
        d0_reg   <= in_depth;
        inv0_reg <= (in_depth == dpwp_pkg::DEPTH_INVALID);
    end

    // Stage 1: camera point scaled by the focal length
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic signed [AW-1:0]  a_next;
    logic signed [AW-1:0]  b_next;
    logic [DKW-1:0]        dk_next;

    assign dx      = $signed({2'b00, col0_reg}) - $signed(DXW'(dpwp_pkg::CENTRE_X));
    assign dy      = $signed({2'b00, row0_reg}) - $signed(DXW'(dpwp_pkg::CENTRE_Y));
    assign a_next  = dx * $signed({1'b0, d0_reg});
    assign b_next  = dy * $signed({1'b0, d0_reg});
    assign dk_next = d0_reg * dpwp_pkg::FOCAL_W'(dpwp_pkg::FOCAL);

    logic                 v1_reg;
    logic                 inv1_reg;
    logic signed [AW-1:0] a1_reg;
    logic signed [AW-1:0] b1_reg;
    logic [DKW-1:0]       dk1_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk) begin
        inv1_reg <= inv0_reg;
        a1_reg   <= a_next;
        b1_reg   <= b_next;
        dk1_reg  <= dk_next;
    end

    // Stage 2: pose products, four per row
    logic signed [PW-1:0]  p_next [4][4];
    logic signed [PW-1:0]  p_reg  [4][4];
    logic signed [MDW-1:0] pd [4];
    logic signed [MFW-1:0] pf [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            pd[r] = $signed(pose[4*r+2]) * $signed({1'b0, dk1_reg});
            pf[r] = $signed(pose[4*r+3]) * $signed((dpwp_pkg::FOCAL_W+1)'(dpwp_pkg::FOCAL));
            p_next[r][0] = $signed(pose[4*r]) * a1_reg;
            p_next[r][1] = $signed(pose[4*r+1]) * b1_reg;
            p_next[r][2] = PW'(pd[r]);
            p_next[r][3] = PW'(pf[r]);
        end
    end

    logic v2_reg;
    logic inv2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        inv2_reg <= inv1_reg;
        p_reg    <= p_next;
    end

    // Stage 3: row sums
    logic signed [SW-1:0] s_next [4];
    logic signed [SW-1:0] s_reg  [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            s_next[r] = $signed({{2{p_reg[r][0][PW-1]}}, p_reg[r][0]})
                      + $signed({{2{p_reg[r][1][PW-1]}}, p_reg[r][1]})
                      + $signed({{2{p_reg[r][2][PW-1]}}, p_reg[r][2]})
                      + $signed({{2{p_reg[r][3][PW-1]}}, p_reg[r][3]});
        end
    end

    logic v3_reg;
    logic inv3_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        inv3_reg <= inv2_reg;
        s_reg    <= s_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = {inv3_reg, s_reg[0], s_reg[1], s_reg[2], s_reg[3]};

endmodule

### hw/rtl/dpwp_queue.sv
`timescale 1ns / 1ps

module dpwp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dpwp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg;
    logic [PTW-1:0]   wr_ptr_next;
    logic [PTW-1:0]   rd_ptr_reg;
    logic [PTW-1:0]   rd_ptr_next;
    logic [CNW-1:0]   count_reg;
    logic [CNW-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    // The back end takes the head every cycle it is present
    assign full      = (count_reg == CNW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTW'(1);
        end
        count_next = count_reg + CNW'(do_push) - CNW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/dpwp_back.sv
`timescale 1ns / 1ps

module dpwp_back #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [4*dpwp_pkg::sum_width(COORD_BITS):0] in_item,
    output logic                                  out_valid,
    output logic                                  out_point_valid,
    output dpwp_pkg::q16_t                        out_x,
    output dpwp_pkg::q16_t                        out_y,
    output dpwp_pkg::q16_t                        out_z
);

    localparam int NL = 3;
    localparam int QB = dpwp_pkg::QUOT_BITS;
    localparam int SW = dpwp_pkg::sum_width(COORD_BITS);
    localparam int NW = SW + dpwp_pkg::SCALE_SHIFT;
    localparam int DW = SW + dpwp_pkg::DIV_K_W;
    localparam int HW = NW - QB;
    localparam int RW = DW + 1;
    localparam logic [QB:0] LIM_POS = (QB+1)'(64'h7FFF_FFFF);
    localparam logic [QB:0] LIM_NEG = (QB+1)'(64'h8000_0000);

    // Unpack the queue item
    logic signed [SW-1:0] num [NL];
    logic signed [SW-1:0] w_in;
    logic                 inv_in;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            num[l] = $signed(in_item[(4-l)*SW-1 -: SW]);
        end
    end
    assign w_in   = $signed(in_item[SW-1:0]);
    assign inv_in = in_item[4*SW];

    // Stage S0: magnitudes, scaled numerators and divisor
    logic [SW-1:0] wmag;
    logic [DW-1:0] dv_next;
    logic [NW-1:0] n_next [NL];
    logic [SW-1:0] nmag   [NL];

    assign wmag    = w_in[SW-1] ? SW'(-w_in) : SW'(w_in);
    assign dv_next = {{dpwp_pkg::DIV_K_W{1'b0}}, wmag}
                   * DW'(dpwp_pkg::DIV_K);

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            nmag[l]   = num[l][SW-1] ? SW'(-num[l]) : SW'(num[l]);
            n_next[l] = {nmag[l], {dpwp_pkg::SCALE_SHIFT{1'b0}}};
        end
    end

    logic          v0_reg;
    logic          inv0_reg;
    logic          wz0_reg;
    logic [DW-1:0] dv0_reg;
    logic [NW-1:0] n0_reg   [NL];
    logic          neg0_reg [NL];
    logic          nz0_reg  [NL];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        inv0_reg <= inv_in;
        wz0_reg  <= (w_in == '0);
        dv0_reg  <= dv_next;
        for (int l = 0; l < NL; l++)
        begin
            n0_reg[l]   <= n_next[l];
            neg0_reg[l] <= num[l][SW-1] ^ w_in[SW-1];
            nz0_reg[l]  <= (num[l] == '0);
        end
    end

    // Divider pipeline state, index 0 loaded by stage S1
    logic          vld_st [QB+1];
    logic          inv_st [QB+1];
    logic          wz_st  [QB+1];
    logic [DW-1:0] dv_st  [QB+1];
    logic [RW-1:0] r_st   [NL][QB+1];
    logic [QB-1:0] low_st [NL][QB+1];
    logic [QB-1:0] q_st   [NL][QB+1];
    logic          ovf_st [NL][QB+1];
    logic          neg_st [NL][QB+1];
    logic          nz_st  [NL][QB+1];

    // Stage S1: quotient overflow check and remainder seed
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_st[0] <= 1'b0;
        end
        else
        begin
            vld_st[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk) begin
        inv_st[0] <= inv0_reg;
        wz_st[0]  <= wz0_reg;
        dv_st[0]  <= dv0_reg;
        for (int l = 0; l < NL; l++)
        begin
            r_st[l][0]   <= {{(RW-HW){1'b0}}, n0_reg[l][NW-1:QB]};
            low_st[l][0] <= n0_reg[l][QB-1:0];
            q_st[l][0]   <= '0;
            ovf_st[l][0] <= ({{(DW-HW){1'b0}}, n0_reg[l][NW-1:QB]} >= dv0_reg);
            neg_st[l][0] <= neg0_reg[l];
            nz_st[l][0]  <= nz0_reg[l];
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [RW-1:0] trial [NL];
        logic          ge    [NL];

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                trial[l] = {r_st[l][k][RW-2:0], low_st[l][k][QB-1]};
                ge[l]    = (trial[l] >= {1'b0, dv_st[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                vld_st[k+1] <= 1'b0;
            end
            else
            begin
                vld_st[k+1] <= vld_st[k];
            end
        end

        always_ff @(posedge clk) begin
            inv_st[k+1] <= inv_st[k];
            wz_st[k+1]  <= wz_st[k];
            dv_st[k+1]  <= dv_st[k];
            for (int l = 0; l < NL; l++)
            begin
                r_st[l][k+1]   <= ge[l] ? (trial[l] - {1'b0, dv_st[k]}) : trial[l];
                low_st[l][k+1] <= {low_st[l][k][QB-2:0], 1'b0};
                q_st[l][k+1]   <= {q_st[l][k][QB-2:0], ge[l]};
                ovf_st[l][k+1] <= ovf_st[l][k];
                neg_st[l][k+1] <= neg_st[l][k];
                nz_st[l][k+1]  <= nz_st[l][k];
            end
        end
    end

    // Rounding, saturation and sign
    logic [QB:0]    qr    [NL];
    logic [QB:0]    lim   [NL];
    logic [QB:0]    mag   [NL];
    logic           rnd   [NL];
    dpwp_pkg::q16_t res   [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            rnd[l] = ({r_st[l][QB], 1'b0} >= {2'b00, dv_st[QB]});
            qr[l]  = {1'b0, q_st[l][QB]} + (QB+1)'(rnd[l]);
            lim[l] = neg_st[l][QB] ? LIM_NEG : LIM_POS;
            mag[l] = (ovf_st[l][QB] || (qr[l] > lim[l])) ? lim[l] : qr[l];
            if (inv_st[QB] || (wz_st[QB] && nz_st[l][QB]))
            begin
                res[l] = '0;
            end
            else if (neg_st[l][QB])
            begin
                res[l] = ~mag[l][dpwp_pkg::COORD_W-1:0] + dpwp_pkg::COORD_W'(1);
            end
            else
            begin
                res[l] = mag[l][dpwp_pkg::COORD_W-1:0];
            end
        end
    end

    logic           done_reg;
    logic           pv_reg;
    dpwp_pkg::q16_t res_reg [NL];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_st[QB];
        end
    end

    always_ff @(posedge clk) begin
        pv_reg  <= !inv_st[QB];
        res_reg <= res;
    end

    assign out_valid       = done_reg;
    assign out_point_valid = pv_reg;
    assign out_x           = res_reg[0];
    assign out_y           = res_reg[1];
    assign out_z           = res_reg[2];

endmodule

### hw/rtl/depth_pixel_to_world_point.sv
// Path: an accepted pixel passes 4 front stages, the queue and 36 back stages, and then
// its result shows with done high.
// Throughput: one pixel per clock while busy is low; the divider is fully pipelined,
// one quotient bit a stage. Results cannot be held off; done is a one-cycle strobe.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the identity pose.
`timescale 1ns / 1ps

module depth_pixel_to_world_point #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dpwp_pkg::PIX_W-1:0]        pixel_column,
    input  logic [dpwp_pkg::PIX_W-1:0]        pixel_row,
    input  logic [dpwp_pkg::DEPTH_W-1:0]      depth_raw,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpwp_pkg::CFG_W-1:0]        cfg_data,
    output logic                              done,
    output logic signed [dpwp_pkg::COORD_W-1:0] world_x,
    output logic signed [dpwp_pkg::COORD_W-1:0] world_y,
    output logic signed [dpwp_pkg::COORD_W-1:0] world_z,
    output logic                              point_valid
);

    localparam int SW     = dpwp_pkg::sum_width(COORD_BITS);
    localparam int ITEM_W = 4 * SW + 1;
    localparam logic [dpwp_pkg::CFG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;
    localparam logic [dpwp_pkg::CFG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;

    // Pose registers, identity at reset
    logic [dpwp_pkg::CFG_W-1:0] pose_reg [dpwp_pkg::NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pose_reg[0] <= ONE_HI;
            pose_reg[1] <= '0;
            pose_reg[2] <= ONE_LO;
            pose_reg[3] <= '0;
            pose_reg[4] <= '0;
            pose_reg[5] <= ONE_HI;
            pose_reg[6] <= '0;
            pose_reg[7] <= ONE_LO;
        end
        else if (cfg_valid && (cfg_index < dpwp_pkg::CFG_IDX_W'(dpwp_pkg::NUM_REGS)))
        begin
            pose_reg[cfg_index[$clog2(dpwp_pkg::NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    // Split registers into the sixteen matrix entries, row-major
    dpwp_pkg::q16_t [dpwp_pkg::NUM_ENTRIES-1:0] pose;

    for (genvar e = 0; e < dpwp_pkg::NUM_ENTRIES; e++)
    begin : g_entry
        if (e % 2 == 0)
        begin : g_hi
            assign pose[e] = pose_reg[e/2][63:32];
        end
        else
        begin : g_lo
            assign pose[e] = pose_reg[e/2][31:0];
        end
    end

    // Front end: back-projection and pose products
    logic              front_valid;
    logic [ITEM_W-1:0] front_item;
    logic              q_full;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;

    assign busy = q_full;

    dpwp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_column(pixel_column),
        .in_row   (pixel_row),
        .in_depth (depth_raw),
        .pose     (pose),
        .out_valid(front_valid),
        .out_item (front_item)
    );

    dpwp_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(dpwp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_data(front_item),
        .full     (q_full),
        .pop_valid(q_valid),
        .pop_data (q_item)
    );

    // Back end: homogeneous divide, scale and saturate
    dpwp_pkg::q16_t bx;
    dpwp_pkg::q16_t by;
    dpwp_pkg::q16_t bz;

    dpwp_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_item        (q_item),
        .out_valid      (done),
        .out_point_valid(point_valid),
        .out_x          (bx),
        .out_y          (by),
        .out_z          (bz)
    );

    assign world_x = $signed(bx);
    assign world_y = $signed(by);
    assign world_z = $signed(bz);

endmodule

### test/depth_pixel_to_world_point_checker.sv
`timescale 1ns / 1ps

module depth_pixel_to_world_point_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [dpwp_pkg::PIX_W-1:0]           pixel_column,
    input  logic [dpwp_pkg::PIX_W-1:0]           pixel_row,
    input  logic [dpwp_pkg::DEPTH_W-1:0]         depth_raw,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [dpwp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpwp_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 done,
    input  logic signed [dpwp_pkg::COORD_W-1:0]  world_x,
    input  logic signed [dpwp_pkg::COORD_W-1:0]  world_y,
    input  logic signed [dpwp_pkg::COORD_W-1:0]  world_z,
    input  logic                                 point_valid,
    output int                                   error_count,
    output int                                   points_pending
);

    typedef struct packed {
        dpwp_pkg::q16_t x;
        dpwp_pkg::q16_t y;
        dpwp_pkg::q16_t z;
        logic valid;
    } world_point_t;

    logic [dpwp_pkg::CFG_W-1:0] pose [dpwp_pkg::NUM_REGS];
    world_point_t               expected_points [$];

    assign points_pending = expected_points.size();

    // Signed Q16.16 pose entry m[row][col]
    function automatic longint pose_coef(int row, int col);
        logic [dpwp_pkg::CFG_W-1:0]   reg_val;
        logic [dpwp_pkg::COORD_W-1:0] half;
        reg_val = pose[2 * row + col / 2];
        half    = (col % 2) ? reg_val[31:0] : reg_val[63:32];
        return longint'(signed'(half));
    endfunction

    // Exact row dot product, scaled by focal * 65536
    function automatic longint row_dot(int row, longint a, longint b, longint d);
        return pose_coef(row, 0) * a + pose_coef(row, 1) * b
             + pose_coef(row, 2) * (d * dpwp_pkg::FOCAL)
             + pose_coef(row, 3) * dpwp_pkg::FOCAL;
    endfunction

    // num / (w * 1000) as Q16.16, rounded half away from zero, saturated
    function automatic dpwp_pkg::q16_t divide_to_q16(longint num, longint w);
        logic [127:0] n, dv, q, r;
        logic [127:0] limit;
        logic         nneg, wneg, neg;
        nneg = num < 0;
        wneg = w < 0;
        n    = nneg ? 128'(-num) : 128'(num);
        dv   = wneg ? 128'(-w) : 128'(w);
        if (dv == 0)
            return (n == 0) ? 32'h0 : (nneg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        n  = n * 8192;
        dv = dv * 125;
        q  = n / dv;
        r  = n % dv;
        if ((r << 1) >= dv)
            q = q + 1;
        neg   = nneg != wneg;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit)
            q = limit;
        return neg ? (32'h0 - q[31:0]) : q[31:0];
    endfunction

    function automatic world_point_t backproject(logic [dpwp_pkg::PIX_W-1:0] col,
                                                 logic [dpwp_pkg::PIX_W-1:0] row,
                                                 logic [dpwp_pkg::DEPTH_W-1:0] depth);
        world_point_t p;
        longint d, a, b, w;
        p = '0;
        if (depth == dpwp_pkg::DEPTH_INVALID)
            return p;
        d = longint'(depth);
        a = (longint'(col) - dpwp_pkg::CENTRE_X) * d;
        b = (longint'(row) - dpwp_pkg::CENTRE_Y) * d;
        w = row_dot(3, a, b, d);
        p.x = divide_to_q16(row_dot(0, a, b, d), w);
        p.y = divide_to_q16(row_dot(1, a, b, d), w);
        p.z = divide_to_q16(row_dot(2, a, b, d), w);
        p.valid = 1'b1;
        return p;
    endfunction

    // Track pose writes, predict on pixel transfers, compare on done
    always @(posedge clk or negedge rst_n)
    begin
        world_point_t want;
        if (!rst_n)
        begin
            pose[0] = 64'h0001_0000_0000_0000;
            pose[1] = 64'h0;
            pose[2] = 64'h0000_0000_0001_0000;
            pose[3] = 64'h0;
            pose[4] = 64'h0;
            pose[5] = 64'h0001_0000_0000_0000;
            pose[6] = 64'h0;
            pose[7] = 64'h0000_0000_0001_0000;
            expected_points.delete();
            error_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected point x=%h y=%h z=%h v=%b",
                                 world_x, world_y, world_z, point_valid);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (want.x !== world_x || want.y !== world_y ||
                        want.z !== world_z || want.valid !== point_valid)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("ERROR: point exp x=%h y=%h z=%h v=%b got x=%h y=%h z=%h v=%b",
                                     want.x, want.y, want.z, want.valid,
                                     world_x, world_y, world_z, point_valid);
                    end
                end
            end
            if (start && !busy)
                expected_points.push_back(backproject(pixel_column, pixel_row, depth_raw));
            if (cfg_valid && cfg_ready && cfg_index < dpwp_pkg::NUM_REGS)
                pose[cfg_index[2:0]] = cfg_data;
        end
    end

endmodule

### test/depth_pixel_to_world_point_test.sv
`timescale 1ns / 1ps

module depth_pixel_to_world_point_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [dpwp_pkg::PIX_W-1:0]       pixel_column = '0;
    logic [dpwp_pkg::PIX_W-1:0]       pixel_row = '0;
    logic [dpwp_pkg::DEPTH_W-1:0]     depth_raw = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dpwp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dpwp_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             done;
    logic signed [dpwp_pkg::COORD_W-1:0] world_x, world_y, world_z;
    logic                             point_valid;
    int                               error_count;
    int                               points_pending;
    int                               cycle_count = 0;
    logic                             idle_free;

    always #5 clk = ~clk;

    depth_pixel_to_world_point DUT (.*);

    depth_pixel_to_world_point_checker checker_i (.*);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One pixel transfer, preceded by a random gap unless idling is off
    task automatic send_pixel(logic [dpwp_pkg::PIX_W-1:0] col,
                              logic [dpwp_pkg::PIX_W-1:0] row,
                              logic [dpwp_pkg::DEPTH_W-1:0] depth);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        = 1'b1;
        pixel_column = col;
        pixel_row    = row;
        depth_raw    = depth;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_pose(logic [dpwp_pkg::CFG_IDX_W-1:0] idx,
                              logic [dpwp_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait for the pipeline to drain before touching the pose
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (points_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Coefficient around +-2.0, or an arbitrary 32-bit pattern
    function automatic logic [31:0] pose_coef(bit wide);
        if (wide)
            return $urandom;
        return $urandom_range(0, 32'h3FFFF) - 32'h20000;
    endfunction

    function automatic logic [dpwp_pkg::DEPTH_W-1:0] random_depth;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return dpwp_pkg::DEPTH_INVALID;
        if (sel < 7)
            return dpwp_pkg::DEPTH_W'($urandom_range(300, 8000));
        return dpwp_pkg::DEPTH_W'($urandom);
    endfunction

    initial
    begin
        logic [31:0] m33;
        idle_free = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pixels under the identity pose
        send_pixel(10'd320, 10'd240, 16'd1000);
        send_pixel(10'd0, 10'd0, 16'd0);
        send_pixel(10'd1023, 10'd1023, 16'd65534);
        send_pixel(10'd0, 10'd1023, 16'd1);
        send_pixel(10'd1023, 10'd0, 16'd65535);
        send_pixel(10'd320, 10'd240, 16'd65535);
        send_pixel(10'd0, 10'd0, 16'd65534);
        send_pixel(10'd1023, 10'd1023, 16'd1);
        send_pixel(10'd639, 10'd479, 16'd4000);
        send_pixel(10'd512, 10'd256, 16'h8000);
        send_pixel(10'd321, 10'd241, 16'd585);
        send_pixel(10'd319, 10'd239, 16'd2);

        for (int phase = 0; phase < 7; phase++)
        begin
            drain();
            case (phase)
                // Mild random rotation-like pose with w near one
                0, 4:
                begin
                    for (int i = 0; i < 6; i++)
                        write_pose(dpwp_pkg::CFG_IDX_W'(i), {pose_coef(0), pose_coef(0)});
                    write_pose(6, {$urandom_range(0, 15) - 32'd8, $urandom_range(0, 15) - 32'd8});
                    m33 = $urandom_range(32'h8000, 32'h20000);
                    write_pose(7, {$urandom_range(0, 63) - 32'd32, m33});
                end
                // Arbitrary patterns everywhere
                1:
                    for (int i = 0; i < dpwp_pkg::NUM_REGS; i++)
                        write_pose(dpwp_pkg::CFG_IDX_W'(i), {pose_coef(1), pose_coef(1)});
                // Largest positive coefficients
                2:
                    for (int i = 0; i < dpwp_pkg::NUM_REGS; i++)
                        write_pose(dpwp_pkg::CFG_IDX_W'(i), 64'h7FFF_FFFF_7FFF_FFFF);
                // Most negative projection, w row zero
                3:
                begin
                    for (int i = 0; i < 6; i++)
                        write_pose(dpwp_pkg::CFG_IDX_W'(i), 64'h8000_0000_8000_0000);
                    write_pose(6, 64'h0);
                    write_pose(7, 64'h0);
                    write_pose(8, 64'h0001_0000_0001_0000);
                    write_pose(8'hFF, 64'h0001_0000_0001_0000);
                end
                // Random projection with w row of zeros, some entries zero
                5:
                begin
                    for (int i = 0; i < 6; i++)
                        write_pose(dpwp_pkg::CFG_IDX_W'(i),
                                   ($urandom_range(0, 3) == 0) ? 64'h0
                                   : {pose_coef(0), pose_coef(0)});
                    write_pose(6, 64'h0);
                    write_pose(7, 64'h0);
                end
                // Back to identity
                default:
                begin
                    write_pose(0, 64'h0001_0000_0000_0000);
                    write_pose(1, 64'h0);
                    write_pose(2, 64'h0000_0000_0001_0000);
                    write_pose(3, 64'h0);
                    write_pose(4, 64'h0);
                    write_pose(5, 64'h0001_0000_0000_0000);
                    write_pose(6, 64'h0);
                    write_pose(7, 64'h0000_0000_0001_0000);
                end
            endcase
            for (int n = 0; n < 262; n++)
            begin
                if (n % 50 == 0)
                    idle_free = ($urandom_range(0, 3) == 0);
                send_pixel(dpwp_pkg::PIX_W'($urandom), dpwp_pkg::PIX_W'($urandom),
                           random_depth());
            end
        end

        drain();
        if (error_count == 0 && points_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
